// ===== rtl/core/skil_pkg.sv =====
// Shared types and constants for the sorted keyed insertion list.
// Holds command and status codes, field widths and the cell control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skil_pkg;

  // Field widths of the command and result beats
  localparam int CMD_W  = 2;
  localparam int TAG_W  = 32;
  localparam int DIST_W = 24;
  localparam int IDX_W  = 6;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  // One list entry
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [TAG_W-1:0]  tag;
    logic [DIST_W-1:0] distance;
  } cell_op_t;

  // Per-cell position info derived from the entry count and the match search
  typedef struct packed {
    logic occupied;
    logic at_end;
    logic pull_right;
  } cell_pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/skil_cmd_if.sv =====
// Command channel of the sorted keyed insertion list: valid/ready plus payload.
// Depends on skil_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface skil_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [skil_pkg::CMD_W-1:0]     command;
  logic [skil_pkg::TAG_W-1:0]     item_tag;
  logic [skil_pkg::DIST_W-1:0]    distance;
  logic [skil_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, command, item_tag, distance, read_index, input ready);
  modport sink   (input valid, command, item_tag, distance, read_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skil_res_if.sv =====
// Result channel of the sorted keyed insertion list: valid/ready plus payload.
// Depends on skil_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface skil_res_if;
  logic                           valid;
  logic                           ready;
  logic [skil_pkg::ST_W-1:0]      status;
  logic [skil_pkg::CNT_W-1:0]     entry_count;
  logic [skil_pkg::TAG_W-1:0]     found_tag;
  logic [skil_pkg::DIST_W-1:0]    found_distance;

  modport source (output valid, status, entry_count, found_tag, found_distance, input ready);
  modport sink   (input valid, status, entry_count, found_tag, found_distance, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skil_cell.sv =====
// One cell of the list chain: holds a single entry, compares it against the
// broadcast operation and shifts with its neighbors. Depends on skil_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skil_cell (
  input  wire logic              clk,
  input  wire skil_pkg::cell_op_t  op,
  input  wire skil_pkg::cell_pos_t pos,
  input  wire logic              left_greater,
  input  wire skil_pkg::entry_t  left_entry,
  input  wire skil_pkg::entry_t  right_entry,
  output skil_pkg::entry_t       entry,
  output logic                   greater,
  output logic                   match
);

  skil_pkg::entry_t entry_next;

  // Compare the held entry against the broadcast key
  assign greater = pos.occupied && (entry.distance > op.distance);
  assign match   = pos.occupied && (entry.tag == op.tag);

  // Pick the next entry: shift right on insert, shift left on remove
  always_comb begin
    entry_next = entry;
    if (op.ins) begin
      if (left_greater) begin
        entry_next = left_entry;
      end else if (greater || pos.at_end) begin
        entry_next.tag      = op.tag;
        entry_next.distance = op.distance;
      end
    end else if (op.rem && pos.pull_right) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_keyed_insertion_list.sv =====
// Sorted keyed insertion list: DEPTH entries of tag and distance in a chain of cells.
// An accepted command is held in a register; the chain update registers its result.
// The next command is taken only once the held one has updated the chain.
// A waiting result holds the chain update and the command side until it is taken.
// Reset clears the entry count and the handshake state; cell contents are not cleared.
// Depends on skil_pkg, skil_cmd_if, skil_res_if and skil_cell.
`timescale 1ns / 1ps
`default_nettype none

module sorted_keyed_insertion_list #(
  parameter int DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  skil_cmd_if.sink    cmd,
  skil_res_if.source  res
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > skil_pkg::IDX_W) ? CW : skil_pkg::IDX_W;
  localparam int CntW = skil_pkg::CNT_W;

  // Command register stage
  logic                          busy;
  logic [skil_pkg::CMD_W-1:0]    op_cmd;
  logic [skil_pkg::TAG_W-1:0]    op_tag;
  logic [skil_pkg::DIST_W-1:0]   op_dist;
  logic [skil_pkg::IDX_W-1:0]    op_idx;

  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;

  skil_pkg::entry_t              entries [DEPTH];
  logic [DEPTH-1:0]              greater_vec;
  logic [DEPTH-1:0]              match_vec;
  logic [DEPTH-1:0]              below_first;
  logic [DEPTH-1:0]              read_hit;
  skil_pkg::cell_op_t            cell_op;

  logic                          exec;
  logic                          full;
  logic                          found;
  logic                          idx_ok;
  skil_pkg::entry_t              rd_entry;
  logic [skil_pkg::ST_W-1:0]     status_next;
  skil_pkg::entry_t              found_next;

  assign cmd.ready = !busy;
  assign exec      = busy && (!res.valid || res.ready);
  assign full      = (count == CW'(DEPTH));
  assign found     = |match_vec;
  assign idx_ok    = CMPW'(op_idx) < CMPW'(count);

  // Mark the cells ahead of the first tag match
  assign below_first = (match_vec - DEPTH'(1)) & ~match_vec;

  // Broadcast the operation to the chain
  always_comb begin
    cell_op.ins      = exec && (op_cmd == skil_pkg::CMD_INSERT) && !full;
    cell_op.rem      = exec && (op_cmd == skil_pkg::CMD_REMOVE) && found;
    cell_op.tag      = op_tag;
    cell_op.distance = op_dist;
  end

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skil_pkg::cell_pos_t pos;
    logic                lg;
    skil_pkg::entry_t    le;
    skil_pkg::entry_t    re;

    assign pos.occupied   = CW'(i) < count;
    assign pos.at_end     = CW'(i) == count;
    assign pos.pull_right = !below_first[i];
    assign read_hit[i]    = CMPW'(i) == CMPW'(op_idx);

    if (i == 0) begin : g_first
      assign lg = 1'b0;
      assign le = entries[i];
    end else begin : g_mid
      assign lg = greater_vec[i-1];
      assign le = entries[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign re = entries[i];
    end else begin : g_inner
      assign re = entries[i+1];
    end

    skil_cell u_cell (
      .clk          (clk),
      .op           (cell_op),
      .pos          (pos),
      .left_greater (lg),
      .left_entry   (le),
      .right_entry  (re),
      .entry        (entries[i]),
      .greater      (greater_vec[i]),
      .match        (match_vec[i])
    );
  end

  // Select the entry at the read index
  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (read_hit[i]) begin
        rd_entry = rd_entry | entries[i];
      end
    end
  end

  // Form status, found fields and the next count
  always_comb begin
    status_next = skil_pkg::ST_OK;
    found_next  = '0;
    count_next  = count;
    case (op_cmd)
      skil_pkg::CMD_INSERT: begin
        if (full) begin
          status_next = skil_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      skil_pkg::CMD_REMOVE: begin
        if (found) begin
          count_next = count - CW'(1);
        end else begin
          status_next = skil_pkg::ST_NOT_FOUND;
        end
      end
      skil_pkg::CMD_READ: begin
        if (idx_ok) begin
          found_next = rd_entry;
        end else begin
          status_next = skil_pkg::ST_BAD_INDEX;
        end
      end
      default: begin
        status_next = skil_pkg::ST_OK;
      end
    endcase
  end

  // Hold the command, advance the count and drive the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        busy <= 1'b1;
      end else if (exec) begin
        busy <= 1'b0;
      end

      if (exec) begin
        count     <= count_next;
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end

    if (cmd.valid && cmd.ready) begin
      op_cmd  <= cmd.command;
      op_tag  <= cmd.item_tag;
      op_dist <= cmd.distance;
      op_idx  <= cmd.read_index;
    end

    if (exec) begin
      res.status         <= status_next;
      res.entry_count    <= CntW'(count_next);
      res.found_tag      <= found_next.tag;
      res.found_distance <= found_next.distance;
    end
  end

endmodule

`default_nettype wire
